[src/mavgw_pkg.sv]
// Shared types and constants for the moving-average filter with warm-up.
// Holds the item and result word formats, register codes and the control states.
// No dependencies.
package mavgw_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int WLEN_BITS = 7;
	localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd64;

	// Byte address layout of the register port: bit 2 selects the register.
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_CLEAR  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                         kind;
		logic signed [SAMPLE_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] average;
		logic                          window_full;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

[src/mavgw_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mavgw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/mavgw_div.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// No package dependencies.
module mavgw_div #(
	parameter int DVD_W = 22,
	parameter int DVS_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic        [DVS_W-1:0] divisor,
	output logic                    done,
	output logic signed [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             take;
	logic [DVD_W-1:0] dvd_mag;

	assign dvd_mag = dividend[DVD_W-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);

	// Restoring step: bring down the next dividend bit and subtract when it fits.
	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dvd_mag;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[DVD_W-1];
		end else if (run_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], take};
			rem_q <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = $signed(neg_q ? (~dq_q + 1'b1) : dq_q);

endmodule

[src/moving_average_warmup.sv]
// Top level of the moving-average filter with warm-up.
// Depends on mavgw_pkg, mavgw_ram and mavgw_div.

// A sample word writes the newest value over the oldest entry of a circular store and
// returns the mean of the stored samples: over the samples seen so far during warm-up,
// over the whole window once it has filled. A clear word (and any write of
// window_length) empties the store and restarts warm-up; its result is zero. One word
// is processed at a time. A sample word's result waits on the iterative divider, which
// produces one quotient bit per cycle. The next word is accepted while a result still
// waits in the output register.
// No clearing pass follows reset: entries not yet written since the last clear are
// read as zero through the warm-up flag, so the block is ready at once.
module moving_average_warmup #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  mavgw_pkg::item_t                       item,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output mavgw_pkg::result_t                     result,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [mavgw_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [mavgw_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [mavgw_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                   pready
);

	import mavgw_pkg::*;

	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(WINDOW_DEPTH);

	state_t state_q, state_d;

	logic [WLEN_BITS-1:0]          wlen_q;
	logic [ADDR_W-1:0]             pos_q;
	logic                          warm_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic                          full_q;
	result_t                       result_q;
	logic                          result_valid_q;

	logic                          item_fire;
	logic                          cfg_write;
	logic                          ram_we;
	logic                          div_start;
	logic                          out_load;
	logic [LEN_W-1:0]              eff_len;
	logic [LEN_W-1:0]              count;
	logic [LEN_W-1:0]              divisor;
	logic                          wrap;
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic signed [SAMPLE_BITS-1:0] old_val;
	logic signed [SUM_W-1:0]       new_sum;
	logic                          div_done;
	logic signed [SUM_W-1:0]       quotient;

	assign item_fire = item_valid && item_ready;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_BITS-1] == REG_WINDOW_LENGTH);

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_BITS-1] == REG_WINDOW_LENGTH)
		? APB_DATA_BITS'(wlen_q) : '0;

	always_comb begin
		if (wlen_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(wlen_q) > WINDOW_DEPTH) begin
			eff_len = DEPTH_LEN;
		end else begin
			eff_len = LEN_W'(wlen_q);
		end
	end

	// The write position never reaches the window length, so during warm-up the entry
	// about to be overwritten has not been written since the last clear and counts as zero.
	assign old_val = warm_q ? $signed(ram_rdata) : '0;
	assign new_sum = sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
	assign count   = LEN_W'(pos_q) + LEN_W'(1);
	assign wrap    = count >= eff_len;
	assign divisor = warm_q ? eff_len : count;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					state_d = (item.kind == KIND_CLEAR) ? ST_DONE : ST_CALC;
				end
			end
			ST_CALC: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		ram_we     = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: item_ready = 1'b1;
			ST_CALC: begin
				ram_we    = 1'b1;
				div_start = 1'b1;
			end
			ST_DIV: ;
			ST_DONE: out_load = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			wlen_q         <= WLEN_RESET;
			pos_q          <= '0;
			warm_q         <= 1'b0;
			sum_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				wlen_q <= pwdata[WLEN_BITS-1:0];
				pos_q  <= '0;
				warm_q <= 1'b0;
				sum_q  <= '0;
			end else if (item_fire && item.kind == KIND_CLEAR) begin
				pos_q  <= '0;
				warm_q <= 1'b0;
				sum_q  <= '0;
			end else if (ram_we) begin
				sum_q  <= new_sum;
				pos_q  <= wrap ? '0 : count[ADDR_W-1:0];
				warm_q <= warm_q || wrap;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			sample_q <= item.sample;
			if (item.kind == KIND_CLEAR) begin
				avg_q  <= '0;
				full_q <= 1'b0;
			end
		end
		if (ram_we) begin
			full_q <= warm_q || wrap;
		end
		if (state_q == ST_DIV && div_done) begin
			avg_q <= quotient[SAMPLE_BITS-1:0];
		end
		if (out_load) begin
			result_q.average     <= avg_q;
			result_q.window_full <= full_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	mavgw_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata($unsigned(sample_q)),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	mavgw_div #(
		.DVD_W(SUM_W),
		.DVS_W(LEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(new_sum),
		.divisor (divisor),
		.done    (div_done),
		.quotient(quotient)
	);

endmodule

[src/mavgw_chk.sv]
// Port-level checker for the moving-average filter, attached to the top level by bind.
// Depends on mavgw_pkg.
module mavgw_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_ready,
	input logic                                result_valid,
	input logic                                result_ready,
	input mavgw_pkg::result_t                  result,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [mavgw_pkg::APB_ADDR_BITS-1:0] paddr,
	input logic [mavgw_pkg::APB_DATA_BITS-1:0] pwdata,
	input logic [mavgw_pkg::APB_DATA_BITS-1:0] prdata,
	input logic                                pready
);

	import mavgw_pkg::*;

	// A result word is held until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped before it was taken");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result word changed while stalled");

	// Only one word is in flight, so the input closes right after an acceptance.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second word accepted while one is in flight");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[APB_ADDR_BITS-1] == REG_WINDOW_LENGTH
		|=> (paddr[APB_ADDR_BITS-1] != REG_WINDOW_LENGTH
			|| prdata[WLEN_BITS-1:0] == $past(pwdata[WLEN_BITS-1:0])))
		else $error("window_length does not read back as written");

	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[APB_DATA_BITS-1:WLEN_BITS] == '0)
		else $error("unused register bits read as nonzero");

endmodule

bind moving_average_warmup mavgw_chk u_chk (.*);
